FILE: sv/pdt_pkg.sv
// ----------------------------------------------------------------------------
// pdt_pkg
// Shared widths, opcodes, controller states and the command and status
// bundles between the controller and the datapath of the deadline timer.
// ----------------------------------------------------------------------------
package pdt_pkg;

  localparam int TIME_BITS_DEF = 64;
  localparam int FIELD_W       = 64;
  localparam int OPCODE_W      = 2;

  localparam logic [OPCODE_W-1:0] OP_POLL   = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_START  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_CANCEL = 2'd2;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EXEC = 6'b000010,
    S_DIV  = 6'b000100,
    S_ADV  = 6'b001000,
    S_SAT  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  typedef struct packed {
    logic load;
    logic start;
    logic cancel;
    logic fire;
    logic stop;
    logic div_init;
    logic div_step;
    logic load_inc;
    logic advance;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [OPCODE_W-1:0] op;
    logic                hit;
    logic                per_zero;
    logic                now_late;
    logic                div_done;
  } sts_t;

endpackage

FILE: sv/pdt_in_if.sv
// ----------------------------------------------------------------------------
// pdt_in_if
// Request channel: opcode, current time, first delay and repeat interval.
// ----------------------------------------------------------------------------
interface pdt_in_if;
  logic                         valid;
  logic                         ready;
  logic [pdt_pkg::OPCODE_W-1:0] opcode;
  logic [pdt_pkg::FIELD_W-1:0]  now_ms;
  logic [pdt_pkg::FIELD_W-1:0]  first_ms;
  logic [pdt_pkg::FIELD_W-1:0]  period_ms;

  modport source (output valid, opcode, now_ms, first_ms, period_ms, input ready);
  modport sink   (input valid, opcode, now_ms, first_ms, period_ms, output ready);
endinterface

FILE: sv/pdt_out_if.sv
// ----------------------------------------------------------------------------
// pdt_out_if
// Result channel: fired flag, running flag and the current deadline.
// ----------------------------------------------------------------------------
interface pdt_out_if;
  logic                        valid;
  logic                        ready;
  logic                        fired;
  logic                        running;
  logic [pdt_pkg::FIELD_W-1:0] next_deadline;

  modport source (output valid, fired, running, next_deadline, input ready);
  modport sink   (input valid, fired, running, next_deadline, output ready);
endinterface

FILE: sv/pdt_ctrl.sv
// ----------------------------------------------------------------------------
// pdt_ctrl
// Sequencer: takes one request, issues datapath commands through the
// bit-serial remainder when a periodic timer fires, then hands off a result.
// ----------------------------------------------------------------------------
module pdt_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  pdt_pkg::sts_t  sts,
  output pdt_pkg::cmd_t  cmd
);

  pdt_pkg::state_t state;
  pdt_pkg::state_t state_next;
  logic            out_valid_next;
  logic            accept;

  assign in_ready = (state == pdt_pkg::S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      pdt_pkg::S_IDLE: begin
        if (accept) begin
          cmd.load   = 1'b1;
          state_next = pdt_pkg::S_EXEC;
        end
      end
      pdt_pkg::S_EXEC: begin
        state_next = pdt_pkg::S_DONE;
        case (sts.op)
          pdt_pkg::OP_START:  cmd.start  = 1'b1;
          pdt_pkg::OP_CANCEL: cmd.cancel = 1'b1;
          pdt_pkg::OP_POLL: begin
            if (sts.hit) begin
              cmd.fire = 1'b1;
              if (sts.per_zero || sts.now_late) begin
                cmd.stop = 1'b1;
              end else begin
                cmd.div_init = 1'b1;
                state_next   = pdt_pkg::S_DIV;
              end
            end
          end
          default: ;
        endcase
      end
      pdt_pkg::S_DIV: begin
        if (sts.div_done) begin
          state_next = pdt_pkg::S_ADV;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      pdt_pkg::S_ADV: begin
        cmd.load_inc = 1'b1;
        state_next   = pdt_pkg::S_SAT;
      end
      pdt_pkg::S_SAT: begin
        cmd.advance = 1'b1;
        state_next  = pdt_pkg::S_DONE;
      end
      pdt_pkg::S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = pdt_pkg::S_IDLE;
        end
      end
      default: state_next = pdt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pdt_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == pdt_pkg::S_EXEC)
    else $error("accepted request did not enter execute");

  a_step_live: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> !sts.div_done)
    else $error("remainder stepped past its last bit");

  a_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result overwrote one not yet transferred");

endmodule

FILE: sv/pdt_dp.sv
// ----------------------------------------------------------------------------
// pdt_dp
// Timer state, request capture, saturating deadline adder, bit-serial
// remainder of the missed gap by the period, and the result register.
// ----------------------------------------------------------------------------
module pdt_dp #(
  parameter int TIME_BITS = pdt_pkg::TIME_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  pdt_pkg::cmd_t                cmd,
  output pdt_pkg::sts_t                sts,
  input  logic [pdt_pkg::OPCODE_W-1:0] opcode,
  input  logic [pdt_pkg::FIELD_W-1:0]  now_ms,
  input  logic [pdt_pkg::FIELD_W-1:0]  first_ms,
  input  logic [pdt_pkg::FIELD_W-1:0]  period_ms,
  output logic                         fired,
  output logic                         running,
  output logic [pdt_pkg::FIELD_W-1:0]  next_deadline
);

  localparam int TB    = TIME_BITS;
  localparam int FW    = pdt_pkg::FIELD_W;
  localparam int CNT_W = $clog2(TIME_BITS + 1);
  localparam logic [TB-1:0]    T_NONE   = {TB{1'b1}};
  localparam logic [TB-1:0]    T_LATEST = {{(TB-1){1'b1}}, 1'b0};
  localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(TIME_BITS);

  logic [pdt_pkg::OPCODE_W-1:0] op_q;
  logic [TB-1:0]                now_q;
  logic [TB-1:0]                dly_q;
  logic [TB-1:0]                per_q;

  logic [TB-1:0]    deadline;
  logic [TB-1:0]    period;
  logic             active;
  logic             hit_fired;

  logic [TB-1:0]    rem;
  logic [TB-1:0]    dvd;
  logic [CNT_W-1:0] cnt;
  logic [TB-1:0]    inc;

  logic [TB:0]      trial;
  logic [TB-1:0]    addend;
  logic [TB:0]      sum;
  logic [TB-1:0]    sat_val;

  assign trial   = {rem, dvd[TB-1]};
  assign addend  = cmd.advance ? inc : dly_q;
  assign sum     = {1'b0, now_q} + {1'b0, addend};
  assign sat_val = (sum >= {1'b0, T_LATEST}) ? T_LATEST : sum[TB-1:0];

  assign sts.op       = op_q;
  assign sts.hit      = active && (now_q >= deadline);
  assign sts.per_zero = (period == '0);
  assign sts.now_late = (now_q >= T_LATEST);
  assign sts.div_done = (cnt == CNT_END);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= opcode;
      now_q <= now_ms[TB-1:0];
      dly_q <= first_ms[TB-1:0];
      per_q <= period_ms[TB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      deadline <= '0;
      period   <= '0;
      active   <= 1'b0;
    end else begin
      if (cmd.start) begin
        deadline <= sat_val;
        period   <= per_q;
        active   <= 1'b1;
      end
      if (cmd.cancel) begin
        deadline <= '0;
        period   <= '0;
        active   <= 1'b0;
      end
      if (cmd.stop) begin
        active <= 1'b0;
      end
      if (cmd.advance) begin
        deadline <= sat_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_fired <= 1'b0;
    end else if (cmd.load) begin
      hit_fired <= 1'b0;
    end else if (cmd.fire) begin
      hit_fired <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.div_init) begin
      cnt <= '0;
    end else if (cmd.div_step) begin
      cnt <= cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem <= '0;
      dvd <= now_q - deadline;
    end else if (cmd.div_step) begin
      if (trial >= {1'b0, period}) begin
        rem <= TB'(trial - {1'b0, period});
      end else begin
        rem <= trial[TB-1:0];
      end
      dvd <= {dvd[TB-2:0], 1'b0};
    end
    if (cmd.load_inc) begin
      inc <= period - rem;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      fired         <= hit_fired;
      running       <= active;
      next_deadline <= FW'(active ? deadline : T_NONE);
    end
  end

  a_active_deadline: assert property (@(posedge clk) disable iff (rst)
    active |-> deadline != T_NONE)
    else $error("active timer holds the no-deadline code");

  a_div_restart: assert property (@(posedge clk) disable iff (rst)
    cmd.div_init |=> cnt == '0)
    else $error("remainder count not restarted");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.load_inc |-> rem < period)
    else $error("remainder not below the period");

endmodule

FILE: sv/periodic_deadline_timer.sv
// ----------------------------------------------------------------------------
// periodic_deadline_timer
// One periodic timer checked against the time carried by each request;
// a late periodic fire skips the missed periods.
//
//   channel  dir   payload                                    transfer when
//   in_ch    sink  opcode, now_ms, first_ms, period_ms        valid && ready
//   out_ch   src   fired, running, next_deadline              valid && ready
//
// Start, cancel, poll without fire and one-shot fire pass through execute
// and done; a periodic fire also runs the one-bit-per-cycle remainder of
// the missed gap by the period before the deadline advances.
// One request in flight; in_ch.ready is high only between requests, and a
// pending result on out_ch does not block the next request.
// Reset (rst, synchronous) clears the timer to inactive with zero deadline.
// ----------------------------------------------------------------------------
module periodic_deadline_timer #(
  parameter int TIME_BITS = pdt_pkg::TIME_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  pdt_in_if.sink    in_ch,
  pdt_out_if.source out_ch
);

  pdt_pkg::cmd_t cmd;
  pdt_pkg::sts_t sts;

  pdt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pdt_dp #(
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .opcode        (in_ch.opcode),
    .now_ms        (in_ch.now_ms),
    .first_ms      (in_ch.first_ms),
    .period_ms     (in_ch.period_ms),
    .fired         (out_ch.fired),
    .running       (out_ch.running),
    .next_deadline (out_ch.next_deadline)
  );

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking regression for periodic_deadline_timer. A scoreboard class
// predicts the fired flag, running flag and deadline of every accepted
// request and compares them in order with the results on out_ch. A directed
// pass covers one-shot and periodic fires, saturation near the latest
// deadline, cancel, the unused opcode and polls while inactive or early.
// Random timer sessions with noise follow, with bursts of idle cycles on
// both channels.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          TIME_W      = pdt_pkg::TIME_BITS_DEF;
  localparam logic [63:0] TMASK       = {64{1'b1}} >> (64 - TIME_W);
  localparam logic [63:0] NO_DEADLINE = TMASK;
  localparam logic [63:0] LATEST      = TMASK - 64'd1;
  localparam logic [1:0]  OP_UNUSED   = 2'd3;
  localparam int          DIRECTED_N  = 26;
  localparam int          TOTAL_N     = DIRECTED_N + 1250;
  localparam int          CALM_N      = 150;

  typedef struct packed {
    logic        fired;
    logic        running;
    logic [63:0] next_deadline;
  } timer_status_t;

  class timer_scoreboard;
    logic [63:0]   dl;
    logic [63:0]   ivl;
    logic          armed;
    timer_status_t status_fifo[$];
    int            errors;

    function new();
      dl     = '0;
      ivl    = '0;
      armed  = 1'b0;
      errors = 0;
    endfunction

    function logic [63:0] capped_sum(logic [63:0] base, logic [63:0] add);
      if (base >= LATEST || add > LATEST - base) return LATEST;
      return base + add;
    endfunction

    function void note_request(logic [1:0] op, logic [63:0] now_raw,
                               logic [63:0] dly_raw, logic [63:0] per_raw);
      logic [63:0]   now;
      logic [63:0]   dly;
      logic [63:0]   per;
      logic [63:0]   gap;
      logic          fired;
      timer_status_t st;
      now   = now_raw & TMASK;
      dly   = dly_raw & TMASK;
      per   = per_raw & TMASK;
      fired = 1'b0;
      case (op)
        pdt_pkg::OP_START: begin
          dl    = capped_sum(now, dly);
          ivl   = per;
          armed = 1'b1;
        end
        pdt_pkg::OP_CANCEL: begin
          dl    = '0;
          ivl   = '0;
          armed = 1'b0;
        end
        pdt_pkg::OP_POLL: begin
          if (armed && now >= dl) begin
            fired = 1'b1;
            if (ivl == '0) begin
              armed = 1'b0;
            end else if (dl == NO_DEADLINE || now >= LATEST) begin
              dl    = NO_DEADLINE;
              armed = 1'b0;
            end else begin
              gap = now - dl;
              dl  = capped_sum(now, ivl - (gap % ivl));
              if (dl == NO_DEADLINE) armed = 1'b0;
            end
          end
        end
        default: ;
      endcase
      st.fired         = fired;
      st.running       = armed;
      st.next_deadline = armed ? (dl & TMASK) : NO_DEADLINE;
      status_fifo.push_back(st);
    endfunction

    function void check_result(logic fired, logic running, logic [63:0] next_deadline);
      timer_status_t st;
      if (status_fifo.size() == 0) begin
        $display("%0t: unexpected result: fired %0b running %0b next_deadline %h",
                 $time, fired, running, next_deadline);
        errors++;
        return;
      end
      st = status_fifo.pop_front();
      if (fired !== st.fired) begin
        $display("%0t: fired mismatch: expected %0b actual %0b", $time, st.fired, fired);
        errors++;
      end
      if (running !== st.running) begin
        $display("%0t: running mismatch: expected %0b actual %0b",
                 $time, st.running, running);
        errors++;
      end
      if (next_deadline !== st.next_deadline) begin
        $display("%0t: next_deadline mismatch: expected %h actual %h",
                 $time, st.next_deadline, next_deadline);
        errors++;
      end
    endfunction

    function int outstanding();
      return status_fifo.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  pdt_in_if  in_ch();
  pdt_out_if out_ch();

  periodic_deadline_timer DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  timer_scoreboard sb = new();
  int              requests_sent = 0;
  logic            calm = 1'b0;
  int              stall_left = 0;

  always #10 clk = ~clk;

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.opcode    = '0;
    in_ch.now_ms    = '0;
    in_ch.first_ms  = '0;
    in_ch.period_ms = '0;
    out_ch.ready    = 1'b0;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] rand_upto(int unsigned lo, int unsigned hi);
    return 64'($urandom_range(hi, lo));
  endfunction

  task automatic send_request(logic [1:0] op, logic [63:0] now,
                              logic [63:0] dly, logic [63:0] per);
    int gap;
    @(negedge clk);
    calm = (requests_sent >= TOTAL_N - CALM_N);
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 4);
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     = 1'b1;
    in_ch.opcode    = op;
    in_ch.now_ms    = now;
    in_ch.first_ms  = dly;
    in_ch.period_ms = per;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_request(op, now, dly, per);
    requests_sent++;
  endtask

  task automatic run_session();
    logic [63:0] t;
    logic [63:0] dly;
    logic [63:0] per;
    int          pick;
    int          polls;
    pick = $urandom_range(0, 9);
    if (pick < 5)      t = {32'h0, $urandom};
    else if (pick < 8) t = rand64();
    else               t = NO_DEADLINE - rand_upto(0, 300);
    pick = $urandom_range(0, 9);
    if (pick < 6)      dly = rand_upto(0, 50);
    else if (pick < 8) dly = rand_upto(0, 2000);
    else if (pick < 9) dly = rand64();
    else               dly = NO_DEADLINE;
    pick = $urandom_range(0, 9);
    if (pick < 2)      per = '0;
    else if (pick < 7) per = rand_upto(1, 60);
    else if (pick < 8) per = rand_upto(61, 100000);
    else if (pick < 9) per = rand64();
    else               per = NO_DEADLINE - rand_upto(0, 2);
    send_request(pdt_pkg::OP_START, t, dly, per);
    polls = $urandom_range(2, 10);
    repeat (polls) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        send_request(pdt_pkg::OP_CANCEL, t, rand64(), rand64());
      end else if (pick == 1) begin
        send_request(OP_UNUSED, rand64(), rand64(), rand64());
      end else if (pick == 2) begin
        send_request(pdt_pkg::OP_START, t, rand_upto(0, 40), rand_upto(0, 40));
      end else begin
        if (pick < 12)      t = t + rand_upto(0, 30);
        else if (pick < 17) t = t + rand_upto(0, 300);
        else if (pick < 19) t = t + {32'h0, $urandom};
        else                t = rand64();
        send_request(pdt_pkg::OP_POLL, t, rand64(), rand64());
      end
    end
  endtask

  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= $urandom_range(0, 3);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
      sb.check_result(out_ch.fired, out_ch.running, out_ch.next_deadline);
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // poll while inactive, unused opcode, one-shot fire
    send_request(pdt_pkg::OP_POLL, 64'd0, 64'd0, 64'd0);
    send_request(OP_UNUSED, NO_DEADLINE, NO_DEADLINE, NO_DEADLINE);
    send_request(pdt_pkg::OP_START, 64'd100, 64'd0, 64'd0);
    send_request(pdt_pkg::OP_POLL, 64'd99, NO_DEADLINE, NO_DEADLINE);
    send_request(pdt_pkg::OP_POLL, 64'd100, 64'd0, 64'd0);
    send_request(pdt_pkg::OP_POLL, 64'd200, 64'd0, 64'd0);
    // saturated start, periodic fire at the latest deadline
    send_request(pdt_pkg::OP_START, NO_DEADLINE, 64'd5, 64'd7);
    send_request(pdt_pkg::OP_POLL, LATEST - 64'd1, 64'd0, 64'd0);
    send_request(pdt_pkg::OP_POLL, LATEST, 64'd0, 64'd0);
    // periodic fire on time and late with skipped periods
    send_request(pdt_pkg::OP_START, 64'd1000, 64'd10, 64'd100);
    send_request(pdt_pkg::OP_POLL, 64'd1010, 64'd0, 64'd0);
    send_request(pdt_pkg::OP_POLL, 64'd1375, 64'd0, 64'd0);
    send_request(OP_UNUSED, rand64(), rand64(), rand64());
    send_request(pdt_pkg::OP_POLL, 64'd1409, 64'd0, 64'd0);
    send_request(pdt_pkg::OP_CANCEL, 64'd1409, NO_DEADLINE, NO_DEADLINE);
    send_request(pdt_pkg::OP_POLL, NO_DEADLINE, 64'd0, 64'd0);
    // maximal delay and period
    send_request(pdt_pkg::OP_START, 64'd0, NO_DEADLINE, NO_DEADLINE);
    send_request(pdt_pkg::OP_START, 64'd10, 64'd5, NO_DEADLINE);
    send_request(pdt_pkg::OP_POLL, 64'd20, 64'd0, 64'd0);
    send_request(pdt_pkg::OP_POLL, LATEST, 64'd0, 64'd0);
    // next deadline saturates, then clock at all ones
    send_request(pdt_pkg::OP_START, LATEST - 64'd10, 64'd3, 64'd4);
    send_request(pdt_pkg::OP_POLL, LATEST - 64'd2, 64'd0, 64'd0);
    send_request(pdt_pkg::OP_POLL, NO_DEADLINE, 64'd0, 64'd0);
    // unit period
    send_request(pdt_pkg::OP_START, 64'd5, 64'd0, 64'd1);
    send_request(pdt_pkg::OP_POLL, 64'd5, 64'd0, 64'd0);
    send_request(pdt_pkg::OP_CANCEL, 64'd0, 64'd0, 64'd0);

    while (requests_sent < TOTAL_N) begin
      if ($urandom_range(0, 9) < 8)
        run_session();
      else
        send_request(2'($urandom_range(0, 3)), rand64(), rand64(), rand64());
    end

    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (TIME_W + 16) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("periodic_deadline_timer regression: pass");
    end else begin
      $display("periodic_deadline_timer regression: fail");
    end
    $finish;
  end

  initial begin
    #15ms;
    $display("%0t: timeout with %0d results outstanding", $time, sb.outstanding());
    $display("periodic_deadline_timer regression: fail");
    $finish;
  end

endmodule

FILE: periodic_deadline_timer.f
sv/pdt_pkg.sv
sv/pdt_in_if.sv
sv/pdt_out_if.sv
sv/pdt_ctrl.sv
sv/pdt_dp.sv
sv/periodic_deadline_timer.sv
tb/testbench.sv
